// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define BFFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is never true outside reset.
`define BFFA_NEVER(lbl, expr, msg) \
    `BFFA_ASSERT(lbl, !(expr), msg)

`endif

// ===== sv/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Constants, word types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bffa_pkg;

    localparam int ARENA_PAGES_DEF = 64;
    localparam int FREE_SLOTS_DEF  = 64;
    localparam int PAGE_BYTES      = 4096;
    localparam int HEADER_BYTES    = 16;
    localparam int PAGE_FREE       = PAGE_BYTES - HEADER_BYTES;

    localparam logic FUNC_FREE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic        func;
        logic [11:0] request_bytes;
        logic [17:0] block_offset;
    } req_word_t;

    typedef struct packed {
        logic [17:0] object_offset;
        logic [1:0]  status;
        logic [6:0]  pages_mapped;
    } rsp_word_t;

    typedef struct packed {
        logic    load;
        logic    scan;
        logic    page_push;
        logic    mv_rd;
        logic    mv_wr;
        logic    take;
        logic    split;
        logic    free_rd;
        logic    free_push;
        logic    set_status;
        status_t code;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic free_ok;
        logic scan_done;
        logic found;
        logic too_big;
        logic arena_full;
        logic table_full;
        logic idx_zero;
        logic idx_one;
        logic out_full;
    } sts_t;

endpackage

// ===== sv/best_fit_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Best-fit free-list allocator
// A free reads the stored block size and pushes the block as a new slot, unless it is
// ignored or refused; an allocate scans the N live slots through the slot memory read
// port, moves each slot ahead of the chosen one back by one list position and takes it,
// pushing a fresh page first when none fits and room allows. One word is in work at a time.
// Reset clears the slot count, list head, page count and output valid at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_fit_free_list_allocator_top #(
    parameter int ARENA_PAGES = bffa_pkg::ARENA_PAGES_DEF,
    parameter int FREE_SLOTS  = bffa_pkg::FREE_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bffa_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bffa_pkg::rsp_word_t rsp_word
);
    import bffa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bffa_dp #(
        .ARENA_PAGES (ARENA_PAGES),
        .FREE_SLOTS  (FREE_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== sv/bffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Best-fit allocator controller
// Sequences search, slot moves, page takes and frees over the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bffa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output bffa_pkg::cmd_t cmd,
    input  bffa_pkg::sts_t sts
);
    import bffa_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_DECODE    = 11'b000_0000_0010,
        S_SCAN      = 11'b000_0000_0100,
        S_NOFIT     = 11'b000_0000_1000,
        S_MV_RD     = 11'b000_0001_0000,
        S_MV_WR     = 11'b000_0010_0000,
        S_TAKE      = 11'b000_0100_0000,
        S_SPLIT     = 11'b000_1000_0000,
        S_FREE_RD   = 11'b001_0000_0000,
        S_FREE_PUSH = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        req_ready  = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_free)
                begin
                    if (!sts.free_ok)
                    begin
                        state_next = S_DONE;
                    end
                    else if (sts.table_full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = ST_TABLE_FULL;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FREE_RD;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    if (!sts.found)
                    begin
                        state_next = S_NOFIT;
                    end
                    else if (sts.idx_zero)
                    begin
                        state_next = S_TAKE;
                    end
                    else
                    begin
                        state_next = S_MV_RD;
                    end
                end
            end
            S_NOFIT:
            begin
                if (sts.too_big || sts.arena_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_EXHAUSTED;
                    state_next     = S_DONE;
                end
                else if (sts.table_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_TABLE_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.page_push = 1'b1;
                    state_next    = S_TAKE;
                end
            end
            S_MV_RD:
            begin
                cmd.mv_rd  = 1'b1;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.mv_wr  = 1'b1;
                state_next = sts.idx_one ? S_TAKE : S_MV_RD;
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_DONE;
            end
            S_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
                state_next  = S_FREE_PUSH;
            end
            S_FREE_PUSH:
            begin
                cmd.free_push = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bffa_dp.sv =====
// ----------------------------------------------------------------------------
// Best-fit allocator datapath
// Slot table ring memory, block size store, search and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bffa_dp #(
    parameter int ARENA_PAGES = bffa_pkg::ARENA_PAGES_DEF,
    parameter int FREE_SLOTS  = bffa_pkg::FREE_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bffa_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bffa_pkg::rsp_word_t rsp_word,
    input  bffa_pkg::cmd_t      cmd,
    output bffa_pkg::sts_t      sts
);
    import bffa_pkg::*;

    localparam int AW          = $clog2(FREE_SLOTS);
    localparam int AW1         = AW + 1;
    localparam int CW          = $clog2(FREE_SLOTS + 1);
    localparam int PGW         = $clog2(ARENA_PAGES + 1);
    localparam int OFF_W       = $clog2(ARENA_PAGES * PAGE_BYTES);
    localparam int STORE_DEPTH = (ARENA_PAGES * PAGE_BYTES) / 8;
    localparam int SI_W        = $clog2(STORE_DEPTH);

    localparam logic [AW-1:0]  LAST_SLOT = AW'(FREE_SLOTS - 1);
    localparam logic [AW:0]    SLOTS_N   = AW1'(FREE_SLOTS);
    localparam logic [CW-1:0]  SLOTS_C   = CW'(FREE_SLOTS);
    localparam logic [PGW-1:0] PAGES_C   = PGW'(ARENA_PAGES);

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [11:0]      size;
    } slot_t;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] j);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, j};
        if (s >= SLOTS_N)
        begin
            s = s - SLOTS_N;
        end
        return s[AW-1:0];
    endfunction

    logic             func_reg;
    logic [12:0]      req_reg;
    logic [17:0]      boff_reg;
    logic [CW-1:0]    count_reg;
    logic [AW-1:0]    head_reg;
    logic [PGW-1:0]   pages_reg;
    logic [CW-1:0]    j_reg;
    logic             pend_reg;
    logic [AW-1:0]    pend_idx_reg;
    logic             found_reg;
    logic [AW-1:0]    best_idx_reg;
    logic [OFF_W-1:0] best_off_reg;
    logic [11:0]      best_size_reg;
    logic [OFF_W-1:0] obj_reg;
    logic [11:0]      rem_reg;
    status_t          status_reg;
    logic             out_valid_reg;
    rsp_word_t        out_word_reg;

    slot_t            slot_mem [FREE_SLOTS];
    slot_t            rd_q;
    logic [11:0]      store_mem [STORE_DEPTH];
    logic [11:0]      store_q;

    logic [AW-1:0]    head_dec;
    logic [AW-1:0]    head_inc;
    logic             issue;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    slot_t            wr_data;
    slot_t            push_data;
    logic             split_ok;
    logic             push_en;
    logic [OFF_W-1:0] page_off;
    logic [OFF_W-1:0] obj_next;
    logic [SI_W-1:0]  take_si;
    logic [SI_W-1:0]  free_si;
    logic             cand_fit;
    logic             cand_better;

    assign head_dec    = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc    = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign issue       = cmd.scan && (j_reg < count_reg);
    assign split_ok    = rem_reg > 12'(HEADER_BYTES);
    assign push_en     = cmd.page_push || (cmd.split && split_ok) || cmd.free_push;
    assign page_off    = OFF_W'({pages_reg, 12'd0});
    assign obj_next    = best_off_reg + OFF_W'(HEADER_BYTES);
    assign take_si     = obj_next[OFF_W-1:3];
    assign free_si     = SI_W'(boff_reg[17:3]);
    assign cand_fit    = {1'b0, rd_q.size} >= req_reg;
    assign cand_better = !found_reg || (rd_q.size < best_size_reg);

    always_comb
    begin
        if (cmd.page_push)
        begin
            push_data.off  = page_off;
            push_data.size = 12'(PAGE_FREE);
        end
        else if (cmd.free_push)
        begin
            push_data.off  = OFF_W'(boff_reg - 18'(HEADER_BYTES));
            push_data.size = store_q;
        end
        else
        begin
            push_data.off  = obj_reg + OFF_W'(req_reg);
            push_data.size = rem_reg - 12'(HEADER_BYTES);
        end
        rd_addr = cmd.mv_rd ? phys(head_reg, best_idx_reg - AW'(1))
                            : phys(head_reg, j_reg[AW-1:0]);
        wr_en   = push_en || cmd.mv_wr;
        wr_addr = cmd.mv_wr ? phys(head_reg, best_idx_reg) : head_dec;
        wr_data = cmd.mv_wr ? rd_q : push_data;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_q <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            store_mem[take_si] <= req_reg[11:0];
        end
        if (cmd.free_rd)
        begin
            store_q <= store_mem[free_si];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            pages_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.page_push || (cmd.split && split_ok) || cmd.free_push)
            begin
                head_reg  <= head_dec;
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.take)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.page_push)
            begin
                pages_reg <= pages_reg + PGW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= req_word.func;
            req_reg    <= ({1'b0, req_word.request_bytes} + 13'd7) & ~13'd7;
            boff_reg   <= req_word.block_offset;
            j_reg      <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
            obj_reg    <= '0;
        end
        if (cmd.scan)
        begin
            if (pend_reg && cand_fit && cand_better)
            begin
                found_reg     <= 1'b1;
                best_idx_reg  <= pend_idx_reg;
                best_off_reg  <= rd_q.off;
                best_size_reg <= rd_q.size;
            end
            pend_reg <= issue;
            if (issue)
            begin
                pend_idx_reg <= j_reg[AW-1:0];
                j_reg        <= j_reg + CW'(1);
            end
        end
        if (cmd.page_push)
        begin
            best_idx_reg  <= '0;
            best_off_reg  <= page_off;
            best_size_reg <= 12'(PAGE_FREE);
        end
        if (cmd.mv_wr)
        begin
            best_idx_reg <= best_idx_reg - AW'(1);
        end
        if (cmd.take)
        begin
            obj_reg <= obj_next;
            rem_reg <= best_size_reg - req_reg[11:0];
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.code;
        end
        if (cmd.out_load)
        begin
            out_word_reg.object_offset <= 18'(obj_reg);
            out_word_reg.status        <= status_reg;
            out_word_reg.pages_mapped  <= 7'(pages_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    always_comb
    begin
        sts.is_free    = (func_reg == FUNC_FREE);
        sts.free_ok    = (boff_reg >= 18'(HEADER_BYTES))
                         && (32'(boff_reg[17:3]) < 32'(STORE_DEPTH));
        sts.scan_done  = !pend_reg && !(j_reg < count_reg);
        sts.found      = found_reg;
        sts.too_big    = req_reg > 13'(PAGE_FREE);
        sts.arena_full = pages_reg >= PAGES_C;
        sts.table_full = count_reg >= SLOTS_C;
        sts.idx_zero   = (best_idx_reg == '0);
        sts.idx_one    = (best_idx_reg == AW'(1));
        sts.out_full   = out_valid_reg && !rsp_ready;
    end

    `BFFA_ASSERT(a_count_bound, count_reg <= SLOTS_C, "Slot count exceeds table depth.")
    `BFFA_ASSERT(a_pages_bound, pages_reg <= PAGES_C, "Pages in use exceed arena size.")
    `BFFA_NEVER(a_push_full, push_en && (count_reg >= SLOTS_C), "Push into a full slot table.")
    `BFFA_ASSERT(a_page_grows, cmd.page_push |=> (pages_reg == $past(pages_reg) + PGW'(1)), "Page take lost.")
    `BFFA_ASSERT(a_err_zero, cmd.out_load && (status_reg != ST_OK) |=> (rsp_word.object_offset == 18'd0), "Error word carries an offset.")

endmodule
